[rtl/jsu_pkg.sv]
package jsu_pkg;

  // Byte codes
  localparam logic [7:0] BYTE_NUL    = 8'h00;
  localparam logic [7:0] BYTE_QUOTE  = 8'h22;
  localparam logic [7:0] BYTE_BSLASH = 8'h5C;
  localparam logic [7:0] BYTE_U      = 8'h75;
  localparam logic [7:0] ESC_B       = 8'h62;
  localparam logic [7:0] ESC_F       = 8'h66;
  localparam logic [7:0] ESC_N       = 8'h6E;
  localparam logic [7:0] ESC_R       = 8'h72;
  localparam logic [7:0] ESC_T       = 8'h74;
  localparam logic [7:0] CTRL_BS     = 8'h08;
  localparam logic [7:0] CTRL_FF     = 8'h0C;
  localparam logic [7:0] CTRL_LF     = 8'h0A;
  localparam logic [7:0] CTRL_CR     = 8'h0D;
  localparam logic [7:0] CTRL_TAB    = 8'h09;

  // Surrogate ranges and UTF-8 limits
  localparam logic [15:0] HIGH_SURR_MIN = 16'hD800;
  localparam logic [15:0] HIGH_SURR_MAX = 16'hDBFF;
  localparam logic [15:0] LOW_SURR_MIN  = 16'hDC00;
  localparam logic [15:0] LOW_SURR_MAX  = 16'hDFFF;
  localparam logic [20:0] SUPP_BASE     = 21'h10000;
  localparam logic [20:0] UTF8_1B_LIM   = 21'h00080;
  localparam logic [20:0] UTF8_2B_LIM   = 21'h00800;
  localparam logic [20:0] UTF8_3B_LIM   = 21'h10000;

  localparam int unsigned RUN_MAX = 4;
  localparam int unsigned QDEPTH  = 4;
  localparam int unsigned QPTR_W  = $clog2(QDEPTH);
  localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);

  // One decoded run: up to four bytes, sent from index 0 up to last_idx
  typedef struct packed {
    logic [RUN_MAX-1:0][7:0] bytes;
    logic [1:0]              last_idx;
    logic                    str_end;
  } jsu_run_t;

  function automatic jsu_run_t single_byte(input logic [7:0] b);
    jsu_run_t r;
    r          = '0;
    r.bytes[0] = b;
    return r;
  endfunction

  function automatic jsu_run_t utf8_encode(input logic [20:0] cp);
    jsu_run_t r;
    r = '0;
    if (cp < UTF8_1B_LIM) begin
      r.bytes[0] = cp[7:0];
      r.last_idx = 2'd0;
    end else if (cp < UTF8_2B_LIM) begin
      r.bytes[0] = {3'b110, cp[10:6]};
      r.bytes[1] = {2'b10, cp[5:0]};
      r.last_idx = 2'd1;
    end else if (cp < UTF8_3B_LIM) begin
      r.bytes[0] = {4'b1110, cp[15:12]};
      r.bytes[1] = {2'b10, cp[11:6]};
      r.bytes[2] = {2'b10, cp[5:0]};
      r.last_idx = 2'd2;
    end else begin
      r.bytes[0] = {5'b11110, cp[20:18]};
      r.bytes[1] = {2'b10, cp[17:12]};
      r.bytes[2] = {2'b10, cp[11:6]};
      r.bytes[3] = {2'b10, cp[5:0]};
      r.last_idx = 2'd3;
    end
    return r;
  endfunction

endpackage

[rtl/jsu_stream_if.sv]
interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface jsu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       string_end;

  modport source (output valid, output out_byte, output run_last, output string_end,
                  input ready);
  modport sink   (input valid, input out_byte, input run_last, input string_end,
                  output ready);
endinterface

[rtl/jsu_front.sv]
module jsu_front import jsu_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  jsu_in_if.sink   in_ch,
  input  logic     q_full,
  output logic     q_push,
  output jsu_run_t q_data
);

  typedef enum logic [5:0] {
    MODE_PLAIN      = 6'b000001,
    MODE_ESC        = 6'b000010,
    MODE_HEX1       = 6'b000100,
    MODE_AFTER_HIGH = 6'b001000,
    MODE_EXPECT_U   = 6'b010000,
    MODE_HEX2       = 6'b100000
  } mode_t;

  mode_t       mode_r, mode_nxt;
  logic [1:0]  hex_pos_r, hex_pos_nxt;
  logic [15:0] hex_val_r, hex_val_nxt;
  logic        hex_stop_r, hex_stop_nxt;
  logic [9:0]  high_half_r, high_half_nxt;

  logic        acc;
  logic [7:0]  b;
  logic        nib_ok;
  logic [3:0]  nib;
  logic [15:0] val_step;
  logic        stop_step;
  logic        hex_done;
  logic        do_plain, do_esc, do_end, emit;
  jsu_run_t    run;

  assign in_ch.ready = !q_full;
  assign acc         = in_ch.valid && in_ch.ready;
  assign b           = in_ch.in_byte;

  always_comb begin
    nib_ok = 1'b1;
    nib    = 4'd0;
    if (b inside {[8'h30:8'h39]}) begin
      nib = 4'(b - 8'h30);
    end else if (b inside {[8'h41:8'h46]}) begin
      nib = 4'(b - 8'h37);
    end else if (b inside {[8'h61:8'h66]}) begin
      nib = 4'(b - 8'h57);
    end else begin
      nib_ok = 1'b0;
    end
  end

  // Freeze the group value at the first non-hex byte
  assign val_step  = (hex_stop_r || !nib_ok) ? hex_val_r : {hex_val_r[11:0], nib};
  assign stop_step = hex_stop_r || !nib_ok;
  assign hex_done  = (hex_pos_r == 2'd3);

  always_comb begin
    mode_nxt      = mode_r;
    hex_pos_nxt   = hex_pos_r;
    hex_val_nxt   = hex_val_r;
    hex_stop_nxt  = hex_stop_r;
    high_half_nxt = high_half_r;
    do_plain      = 1'b0;
    do_esc        = 1'b0;
    do_end        = 1'b0;
    emit          = 1'b0;
    run           = '0;

    case (mode_r)
      MODE_PLAIN: begin
        do_plain = 1'b1;
      end
      MODE_AFTER_HIGH: begin
        if (b == BYTE_BSLASH) begin
          mode_nxt = MODE_EXPECT_U;
        end else begin
          do_plain = 1'b1;
        end
      end
      MODE_ESC: begin
        do_esc = 1'b1;
      end
      MODE_EXPECT_U: begin
        if (b == BYTE_U) begin
          mode_nxt     = MODE_HEX2;
          hex_pos_nxt  = 2'd0;
          hex_val_nxt  = '0;
          hex_stop_nxt = 1'b0;
        end else begin
          do_esc = 1'b1;
        end
      end
      MODE_HEX1, MODE_HEX2: begin
        if (b == BYTE_NUL) begin
          do_end = 1'b1;
        end else begin
          hex_pos_nxt  = hex_pos_r + 2'd1;
          hex_val_nxt  = val_step;
          hex_stop_nxt = stop_step;
          if (hex_done) begin
            mode_nxt = MODE_PLAIN;
            if (mode_r == MODE_HEX1) begin
              if (val_step >= HIGH_SURR_MIN && val_step <= HIGH_SURR_MAX) begin
                high_half_nxt = val_step[9:0];
                mode_nxt      = MODE_AFTER_HIGH;
              end else if (val_step != 16'd0 &&
                           !(val_step >= LOW_SURR_MIN && val_step <= LOW_SURR_MAX)) begin
                emit = 1'b1;
                run  = utf8_encode({5'd0, val_step});
              end
            end else if (val_step >= LOW_SURR_MIN && val_step <= LOW_SURR_MAX) begin
              emit = 1'b1;
              run  = utf8_encode(SUPP_BASE + {1'b0, high_half_r, val_step[9:0]});
            end
          end
        end
      end
      default: begin
        do_plain = 1'b1;
      end
    endcase

    if (do_plain) begin
      if (b == BYTE_NUL || b == BYTE_QUOTE) begin
        do_end = 1'b1;
      end else if (b == BYTE_BSLASH) begin
        mode_nxt = MODE_ESC;
      end else begin
        mode_nxt = MODE_PLAIN;
        emit     = 1'b1;
        run      = single_byte(b);
      end
    end

    if (do_esc) begin
      mode_nxt = MODE_PLAIN;
      case (b)
        BYTE_NUL: do_end = 1'b1;
        BYTE_U: begin
          mode_nxt     = MODE_HEX1;
          hex_pos_nxt  = 2'd0;
          hex_val_nxt  = '0;
          hex_stop_nxt = 1'b0;
        end
        ESC_B:   begin emit = 1'b1; run = single_byte(CTRL_BS);  end
        ESC_F:   begin emit = 1'b1; run = single_byte(CTRL_FF);  end
        ESC_N:   begin emit = 1'b1; run = single_byte(CTRL_LF);  end
        ESC_R:   begin emit = 1'b1; run = single_byte(CTRL_CR);  end
        ESC_T:   begin emit = 1'b1; run = single_byte(CTRL_TAB); end
        default: begin emit = 1'b1; run = single_byte(b);        end
      endcase
    end

    // End of string: drop all pending state and send the terminator
    if (do_end) begin
      mode_nxt      = MODE_PLAIN;
      hex_pos_nxt   = 2'd0;
      hex_val_nxt   = '0;
      hex_stop_nxt  = 1'b0;
      high_half_nxt = '0;
      emit          = 1'b1;
      run           = single_byte(BYTE_NUL);
      run.str_end   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_PLAIN;
      hex_pos_r   <= '0;
      hex_val_r   <= '0;
      hex_stop_r  <= 1'b0;
      high_half_r <= '0;
    end else if (acc) begin
      mode_r      <= mode_nxt;
      hex_pos_r   <= hex_pos_nxt;
      hex_val_r   <= hex_val_nxt;
      hex_stop_r  <= hex_stop_nxt;
      high_half_r <= high_half_nxt;
    end
  end

  assign q_push = acc && emit;
  assign q_data = run;

  a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
    q_push && q_data.str_end |=> mode_r == MODE_PLAIN && high_half_r == '0)
    else $error("string end left decoder state behind");

endmodule

[rtl/jsu_queue.sv]
module jsu_queue import jsu_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  jsu_run_t push_data,
  output logic     full,
  input  logic     pop,
  output jsu_run_t head,
  output logic     empty
);

  jsu_run_t          slot_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;

  assign full  = (count_r == QCNT_W'(QDEPTH));
  assign empty = (count_r == '0);
  assign head  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_r + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("run queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("run queue read while empty");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QDEPTH))
    else $error("run queue count out of range");

endmodule

[rtl/jsu_back.sv]
module jsu_back import jsu_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  jsu_run_t  head,
  input  logic      empty,
  output logic      pop,
  jsu_out_if.source out_ch
);

  logic [1:0] idx_r;
  logic       last;
  logic       fire;

  assign last              = (idx_r == head.last_idx);
  assign fire              = out_ch.valid && out_ch.ready;
  assign out_ch.valid      = !empty;
  assign out_ch.out_byte   = head.bytes[idx_r];
  assign out_ch.run_last   = last;
  assign out_ch.string_end = head.str_end;
  assign pop               = fire && last;

  // Advance through the run, rewind when it drains
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (fire) begin
      idx_r <= last ? 2'd0 : idx_r + 2'd1;
    end
  end

  a_idx_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> idx_r <= head.last_idx)
    else $error("byte index ran past end of run");

  a_rewind: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> idx_r == 2'd0)
    else $error("byte index not rewound after run");

endmodule

[rtl/json_string_unescape_utf8_top.sv]
// JSON string body unescaper with UTF-8 output.
// in_ch carries one byte of a string body per request, starting after the
// opening quote. out_ch carries decoded bytes: each request yields a run of
// zero to four bytes, run_last marks the final byte of a run, and a closing
// quote or NUL yields a single zero byte with string_end set, after which the
// next byte begins a new string.
// The first byte of a run is registered in the run queue before it appears on
// out_ch. Throughput: one input byte per cycle while runs are one byte long
// and the queue is not full; the output drains one byte per cycle while the
// receiver is ready. A four-entry run queue sits between the decoder and
// the byte serializer, so input keeps flowing while multi-byte runs drain.
// When the receiver stalls, the current byte holds on out_ch and in_ch.ready
// drops once the queue is full.
// Reset (rst_n low, synchronous) empties the queue and returns the decoder to
// plain copy mode with all escape state cleared.
module json_string_unescape_utf8_top import jsu_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  jsu_in_if.sink    in_ch,
  jsu_out_if.source out_ch
);

  logic     q_push, q_full, q_pop, q_empty;
  jsu_run_t q_data, q_head;

  jsu_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_data)
  );

  jsu_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  jsu_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (q_head),
    .empty  (q_empty),
    .pop    (q_pop),
    .out_ch (out_ch)
  );

endmodule

[dv/json_string_unescape_utf8_top_tb.sv]
`timescale 1ns / 1ps

module json_string_unescape_utf8_top_tb import jsu_pkg::*;;

  localparam int unsigned CYCLE_LIMIT = 100000;
  localparam int unsigned SETTLE_CYCLES = 20;

  typedef enum logic [5:0] {
    ST_PLAIN      = 6'b000001,
    ST_ESCAPE     = 6'b000010,
    ST_HEX_FIRST  = 6'b000100,
    ST_AFTER_HIGH = 6'b001000,
    ST_WANT_U     = 6'b010000,
    ST_HEX_SECOND = 6'b100000
  } unescape_state_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       string_end;
  } utf8_byte_t;

  class unescape_scoreboard;
    unescape_state_t state;
    logic [1:0]      digit_idx;
    logic [15:0]     group_val;
    logic            group_broken;
    logic [9:0]      high_bits;
    utf8_byte_t      utf8_q[$];
    int unsigned     errors;

    function new();
      clear_state();
      errors = 0;
    endfunction

    function void clear_state();
      state        = ST_PLAIN;
      digit_idx    = '0;
      group_val    = '0;
      group_broken = 1'b0;
      high_bits    = '0;
    endfunction

    function void start_group();
      digit_idx    = '0;
      group_val    = '0;
      group_broken = 1'b0;
    endfunction

    function void push(input logic [7:0] b, input logic last, input logic done);
      utf8_byte_t e;
      e.out_byte   = b;
      e.run_last   = last;
      e.string_end = done;
      utf8_q.push_back(e);
    endfunction

    function void end_string();
      clear_state();
      push(8'h00, 1'b1, 1'b1);
    endfunction

    function void emit_code_point(input logic [20:0] cp);
      if (cp < UTF8_1B_LIM) begin
        push(cp[7:0], 1'b1, 1'b0);
      end else if (cp < UTF8_2B_LIM) begin
        push({3'b110, cp[10:6]}, 1'b0, 1'b0);
        push({2'b10, cp[5:0]}, 1'b1, 1'b0);
      end else if (cp < UTF8_3B_LIM) begin
        push({4'b1110, cp[15:12]}, 1'b0, 1'b0);
        push({2'b10, cp[11:6]}, 1'b0, 1'b0);
        push({2'b10, cp[5:0]}, 1'b1, 1'b0);
      end else begin
        push({5'b11110, cp[20:18]}, 1'b0, 1'b0);
        push({2'b10, cp[17:12]}, 1'b0, 1'b0);
        push({2'b10, cp[11:6]}, 1'b0, 1'b0);
        push({2'b10, cp[5:0]}, 1'b1, 1'b0);
      end
    endfunction

    function void plain(input logic [7:0] b);
      state = ST_PLAIN;
      if (b == BYTE_NUL || b == BYTE_QUOTE) end_string();
      else if (b == BYTE_BSLASH) state = ST_ESCAPE;
      else push(b, 1'b1, 1'b0);
    endfunction

    function void escaped(input logic [7:0] b);
      state = ST_PLAIN;
      case (b)
        BYTE_NUL: end_string();
        BYTE_U: begin
          state = ST_HEX_FIRST;
          start_group();
        end
        ESC_B: push(CTRL_BS, 1'b1, 1'b0);
        ESC_F: push(CTRL_FF, 1'b1, 1'b0);
        ESC_N: push(CTRL_LF, 1'b1, 1'b0);
        ESC_R: push(CTRL_CR, 1'b1, 1'b0);
        ESC_T: push(CTRL_TAB, 1'b1, 1'b0);
        default: push(b, 1'b1, 1'b0);
      endcase
    endfunction

    // Returns 1 once the fourth byte of a group has been taken
    function logic take_digit(input logic [7:0] b);
      logic [4:0] d;
      d = 5'd16;
      if (b >= 8'h30 && b <= 8'h39) d = 5'(b - 8'h30);
      else if (b >= 8'h41 && b <= 8'h46) d = 5'(b - 8'h41 + 8'd10);
      else if (b >= 8'h61 && b <= 8'h66) d = 5'(b - 8'h61 + 8'd10);
      if (!group_broken) begin
        if (d < 5'd16) group_val = {group_val[11:0], d[3:0]};
        else group_broken = 1'b1;
      end
      if (digit_idx == 2'd3) begin
        digit_idx = '0;
        return 1'b1;
      end
      digit_idx = digit_idx + 2'd1;
      return 1'b0;
    endfunction

    function void note_input(input logic [7:0] b);
      case (state)
        ST_ESCAPE: escaped(b);
        ST_HEX_FIRST: begin
          if (b == BYTE_NUL) begin
            end_string();
          end else if (take_digit(b)) begin
            state = ST_PLAIN;
            if (group_val >= HIGH_SURR_MIN && group_val <= HIGH_SURR_MAX) begin
              high_bits = group_val[9:0];
              state     = ST_AFTER_HIGH;
            end else if (group_val != 16'h0000 &&
                         !(group_val >= LOW_SURR_MIN && group_val <= LOW_SURR_MAX)) begin
              emit_code_point({5'd0, group_val});
            end
          end
        end
        ST_AFTER_HIGH: begin
          if (b == BYTE_BSLASH) state = ST_WANT_U;
          else plain(b);
        end
        ST_WANT_U: begin
          if (b == BYTE_U) begin
            state = ST_HEX_SECOND;
            start_group();
          end else begin
            escaped(b);
          end
        end
        ST_HEX_SECOND: begin
          if (b == BYTE_NUL) begin
            end_string();
          end else if (take_digit(b)) begin
            state = ST_PLAIN;
            if (group_val >= LOW_SURR_MIN && group_val <= LOW_SURR_MAX)
              emit_code_point(SUPP_BASE + {1'b0, high_bits, group_val[9:0]});
          end
        end
        default: plain(b);
      endcase
    endfunction

    function void report(input string msg);
      errors++;
      if (errors <= 10) $display("%s", msg);
    endfunction

    function void check_output(input logic [7:0] b, input logic last, input logic done);
      utf8_byte_t e;
      if (utf8_q.size() == 0) begin
        report($sformatf("unexpected output byte %02h last %0b end %0b", b, last, done));
        return;
      end
      e = utf8_q.pop_front();
      if (b !== e.out_byte || last !== e.run_last || done !== e.string_end)
        report($sformatf("mismatch: expected byte %02h last %0b end %0b, got %02h %0b %0b",
                         e.out_byte, e.run_last, e.string_end, b, last, done));
    endfunction

    function int unsigned pending();
      return utf8_q.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned bytes_sent;
  unescape_scoreboard sb;

  jsu_in_if  in_ch ();
  jsu_out_if out_ch ();

  json_string_unescape_utf8_top i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Note the request before checking output, both sampled at the same edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) sb.note_input(in_ch.in_byte);
      if (out_ch.valid && out_ch.ready)
        sb.check_output(out_ch.out_byte, out_ch.run_last, out_ch.string_end);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return 8'h30 + n;
    return ($urandom_range(1) ? 8'h41 : 8'h61) + n - 8'd10;
  endfunction

  task automatic send_unicode(input logic [15:0] v);
    send_byte(BYTE_BSLASH);
    send_byte(BYTE_U);
    for (int i = 3; i >= 0; i--) send_byte(hex_char(v[i*4 +: 4]));
  endtask

  // Hold valid low until every expected byte is out
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic send_directed();
    send_text("A");
    send_byte(8'hFF);
    send_byte(8'h01);
    send_text("\\b\\f\\n\\r\\t\\\\\\\"");
    send_byte(BYTE_BSLASH);
    send_byte(8'hFF);
    send_text("\\u0000\\u007f\\u00e9\\uFFFF\\u0800");
    send_text("\\uD800\\uDC00\\uDBFF\\uDFFF\\ud83d\\ude00");
    // lone low, high then plain, high then other escape, high then non-low
    send_text("\\uDC00\\uD800x\\uD800\\n\\uD800\\u0041");
    // quote and non-hex byte inside a group stop the value
    send_text("\\u1\"23\\u12z4");
    send_byte(BYTE_QUOTE);
    send_byte(BYTE_NUL);
    send_byte(BYTE_BSLASH);
    send_byte(BYTE_NUL);
    send_text("\\u1");
    send_byte(BYTE_NUL);
    send_text("\\uD800\\u");
    send_byte(BYTE_NUL);
    send_text("\\uDBFF");
    send_byte(BYTE_NUL);
  endtask

  task automatic send_random_token();
    logic [7:0]  b;
    logic [15:0] v;
    int unsigned bad_pos;
    case ($urandom_range(19))
      0, 1, 2, 3, 4, 5: begin
        do b = 8'($urandom_range(255, 1)); while (b == BYTE_QUOTE || b == BYTE_BSLASH);
        send_byte(b);
      end
      6: send_byte(8'($urandom_range(255)));
      7, 8: begin
        send_byte(BYTE_BSLASH);
        case ($urandom_range(4))
          0: send_byte(ESC_B);
          1: send_byte(ESC_F);
          2: send_byte(ESC_N);
          3: send_byte(ESC_R);
          default: send_byte(ESC_T);
        endcase
      end
      9: begin
        send_byte(BYTE_BSLASH);
        send_byte(8'($urandom_range(255)));
      end
      10, 11, 12: begin
        case ($urandom_range(5))
          0: v = 16'h0000;
          1: v = 16'($urandom_range(16'h007F, 16'h0001));
          2: v = 16'($urandom_range(16'h07FF, 16'h0080));
          3: v = 16'($urandom_range(16'hD7FF, 16'h0800));
          4: v = 16'($urandom_range(16'hFFFF, 16'hE000));
          default: v = 16'($urandom_range(16'hFFFF));
        endcase
        send_unicode(v);
      end
      13, 14, 15: begin
        send_unicode(16'($urandom_range(HIGH_SURR_MAX, HIGH_SURR_MIN)));
        if ($urandom_range(5) == 0) send_unicode(16'($urandom_range(16'hFFFF)));
        else send_unicode(16'($urandom_range(LOW_SURR_MAX, LOW_SURR_MIN)));
      end
      16: send_unicode(16'($urandom_range(LOW_SURR_MAX, LOW_SURR_MIN)));
      17: begin
        bad_pos = $urandom_range(3);
        send_byte(BYTE_BSLASH);
        send_byte(BYTE_U);
        for (int i = 0; i < 4; i++) begin
          if (i == bad_pos) send_byte(8'($urandom_range(255)));
          else send_byte(hex_char(4'($urandom_range(15))));
        end
      end
      18: begin
        send_unicode(16'($urandom_range(HIGH_SURR_MAX, HIGH_SURR_MIN)));
        send_byte(8'($urandom_range(255)));
      end
      default: send_byte($urandom_range(1) ? BYTE_QUOTE : BYTE_NUL);
    endcase
  endtask

  task automatic run_random(input int unsigned count);
    int unsigned stop_at;
    stop_at = bytes_sent + count;
    while (bytes_sent < stop_at) send_random_token();
  endtask

  initial begin
    clk           = 1'b0;
    rst_n         = 1'b0;
    bytes_sent    = 0;
    send_idle_pct = 27;
    recv_idle_pct = 88;
    in_ch.valid   = 1'b0;
    in_ch.in_byte = 8'h00;
    sb            = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    send_directed();
    run_random(100);
    drain();

    send_idle_pct = 88;
    recv_idle_pct = 27;
    run_random(100);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(100);
    drain();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.pending() != 0) sb.report("expected output bytes never arrived");
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/jsu_pkg.sv
rtl/jsu_stream_if.sv
rtl/jsu_front.sv
rtl/jsu_queue.sv
rtl/jsu_back.sv
rtl/json_string_unescape_utf8_top.sv
dv/json_string_unescape_utf8_top_tb.sv
